// File: hdl/fpng_pkg.sv
// ----------------------------------------------------------------------------
// fpng_pkg: shared types and constants of the filtered pink noise generator
// Field widths, register indexes, sequencer command group and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package fpng_pkg;

  // default number of octave rows
  localparam int OCTAVES_DEF = 8;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int SUM_W    = 20;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 2;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = 56;

  // reciprocal scaling for the divide by the octave count
  localparam int DIV_SHIFT = 24;

  // unity weight of the low-pass filter, unsigned Q1.15
  localparam logic [GAIN_W-1:0] ALPHA_ONE = 16'h8000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN   = 2'd2;

  // one command per sequencer step
  typedef struct packed {
    logic load;   // capture input sample, bump counter
    logic row;    // update one octave row and the running sum
    logic div;    // multiply |sum| by the reciprocal
    logic raw;    // restore sign of the quotient
    logic filt;   // multiply alpha by (raw - previous)
    logic acc;    // round and saturate the filter output
    logic gain1;  // multiply by master gain
    logic gain2;  // multiply by distance gain
    logic res;    // round, saturate and load the result register
  } cmd_t;

  // saturate a signed value to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [23:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fpng_ctrl.sv
// ----------------------------------------------------------------------------
// fpng_ctrl: sequencer of the pink noise generator
// Walks the octave rows, steps the shared multiplier and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fpng_ctrl import fpng_pkg::*; #(
  parameter int OCTAVES = OCTAVES_DEF,
  parameter int IDXW    = $clog2(OCTAVES)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output cmd_t                 cmd,
  output logic [IDXW-1:0]      row_idx
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROW   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RAW   = 4'd3;
  localparam logic [3:0] S_FILT  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_GAIN1 = 4'd6;
  localparam logic [3:0] S_GAIN2 = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [IDXW-1:0] ROW_LAST = IDXW'(OCTAVES - 1);

  logic [3:0]      state_r, state_nxt;
  logic [IDXW-1:0] row_idx_r, row_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            res_go;

  // input transfer only from idle
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  // result register free or being emptied this cycle
  assign res_go   = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // next state and row walk
  always_comb begin
    state_nxt   = state_r;
    row_idx_nxt = row_idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_ROW;
          row_idx_nxt = '0;
        end
      end
      S_ROW: begin
        if (row_idx_r == ROW_LAST) begin
          state_nxt = S_DIV;
        end else begin
          row_idx_nxt = row_idx_r + 1'b1;
        end
      end
      S_DIV:   state_nxt = S_RAW;
      S_RAW:   state_nxt = S_FILT;
      S_FILT:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_GAIN1;
      S_GAIN1: state_nxt = S_GAIN2;
      S_GAIN2: state_nxt = S_OUT;
      S_OUT: begin
        if (res_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd       = '0;
    cmd.load  = accept;
    cmd.row   = (state_r == S_ROW);
    cmd.div   = (state_r == S_DIV);
    cmd.raw   = (state_r == S_RAW);
    cmd.filt  = (state_r == S_FILT);
    cmd.acc   = (state_r == S_ACC);
    cmd.gain1 = (state_r == S_GAIN1);
    cmd.gain2 = (state_r == S_GAIN2);
    cmd.res   = res_go;
  end

  // result valid: set on load, cleared on output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_idx_r   <= row_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign row_idx   = row_idx_r;

  // accepted sample starts the row walk
  a_accept_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ROW && row_idx_r == '0))
    else $error("row walk did not start after input transfer");

  // row walk stays inside the row store
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW) |-> (row_idx_r <= ROW_LAST))
    else $error("row index beyond last octave row");

  // a new result appears only after the output step
  a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result valid raised outside output step");

  // a blocked result holds the sequencer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("sequencer left output step while result was blocked");

endmodule

`default_nettype wire

// File: hdl/fpng_dp.sv
// ----------------------------------------------------------------------------
// fpng_dp: datapath of the pink noise generator
// Octave rows, running sum, shared multiplier, filter state and gain chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fpng_dp import fpng_pkg::*; #(
  parameter int OCTAVES = OCTAVES_DEF,
  parameter int IDXW    = $clog2(OCTAVES)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [GAIN_W-1:0]           cfg_wdata,
  input  wire logic signed [SAMPLE_W-1:0]  in_white_sample,
  input  wire cmd_t                        cmd,
  input  wire logic [IDXW-1:0]             row_idx,
  output logic signed [SAMPLE_W-1:0]       out_pink_sample
);

  // ceil(2^DIV_SHIFT / OCTAVES), exact for every reachable sum
  localparam logic [MUL_B_W-1:0] RECIP =
    MUL_B_W'(((64'd1 << DIV_SHIFT) + 64'(OCTAVES) - 64'd1) / 64'(OCTAVES));

  // configuration registers
  logic [GAIN_W-1:0] coef_r, master_r, dist_r;

  // item state
  logic signed [SAMPLE_W-1:0] rows_r [OCTAVES];
  logic signed [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [SAMPLE_W-1:0] prev_r;

  // working registers
  logic signed [SAMPLE_W-1:0] half_r;
  logic signed [SAMPLE_W-1:0] raw_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] out_r;

  logic [CNT_W-1:0]           row_mask;
  logic                       row_hit;
  logic signed [SUM_W-1:0]    row_delta;
  logic signed [SUM_W-1:0]    sum_abs;
  logic [SAMPLE_W-1:0]        quot;
  logic signed [SAMPLE_W-1:0] raw_nxt;
  logic signed [SAMPLE_W:0]   diff;
  logic [GAIN_W-1:0]          alpha;
  logic signed [36:0]         acc_sum;
  logic signed [36:0]         acc_sh;
  logic signed [47:0]         gain_sum;
  logic signed [47:0]         gain_sh;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic signed [56:0]         mul_full;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= ALPHA_ONE;
      master_r <= GAIN_RESET;
      dist_r   <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FILTER_COEF: coef_r   <= cfg_wdata;
        REG_MASTER_GAIN: master_r <= cfg_wdata;
        REG_DIST_GAIN:   dist_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row i refreshes when the low i counter bits are zero (all bits past 8)
  always_comb begin
    if (32'(row_idx) >= CNT_W) begin
      row_mask = '1;
    end else begin
      row_mask = CNT_W'(({{CNT_W{1'b0}}, 1'b1} << row_idx) - 1'b1);
    end
  end
  assign row_hit   = ((count_r & row_mask) == '0);
  assign row_delta = SUM_W'(half_r) - SUM_W'(rows_r[row_idx]);

  // octave rows, running sum, counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OCTAVES; i++) begin
        rows_r[i] <= '0;
      end
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      if (cmd.load) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.row && row_hit) begin
        rows_r[row_idx] <= half_r;
        sum_r           <= sum_r + row_delta;
      end
    end
  end

  // half-scaled input sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      half_r <= in_white_sample >>> 1;
    end
  end

  // quotient sign restore, truncation toward zero
  assign sum_abs = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign quot    = prod_r[DIV_SHIFT+SAMPLE_W-1:DIV_SHIFT];
  assign raw_nxt = sum_r[SUM_W-1] ? -$signed(quot) : $signed(quot);

  always_ff @(posedge clk) begin
    if (cmd.raw) begin
      raw_r <= raw_nxt;
    end
  end

  // filter as prev + alpha*(raw - prev)
  assign alpha = (coef_r > ALPHA_ONE) ? ALPHA_ONE : coef_r;
  assign diff  = (SAMPLE_W+1)'(raw_r) - (SAMPLE_W+1)'(prev_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.div) begin
      mul_a = MUL_A_W'(sum_abs);
      mul_b = RECIP;
    end else if (cmd.filt) begin
      mul_a = MUL_A_W'(diff);
      mul_b = MUL_B_W'(alpha);
    end else if (cmd.gain1) begin
      mul_a = MUL_A_W'(prev_r);
      mul_b = MUL_B_W'(master_r);
    end else if (cmd.gain2) begin
      mul_a = $signed(prod_r[MUL_A_W-1:0]);
      mul_b = MUL_B_W'(dist_r);
    end
  end

  assign mul_full = $signed({{25{mul_a[MUL_A_W-1]}}, mul_a}) *
                    $signed({33'd0, mul_b});

  always_ff @(posedge clk) begin
    if (cmd.div || cmd.filt || cmd.gain1 || cmd.gain2) begin
      prod_r <= mul_full[PROD_W-1:0];
    end
  end

  // filter output: round half up by 2^15, saturate
  assign acc_sum = 37'($signed(prod_r[33:0])) + (37'(prev_r) <<< 15) + 37'sd16384;
  assign acc_sh  = acc_sum >>> 15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.acc) begin
      prev_r <= sat16(acc_sh[23:0]);
    end
  end

  // gained result: round half up by 2^30, saturate
  assign gain_sum = $signed(prod_r[47:0]) + 48'sh0000_2000_0000;
  assign gain_sh  = gain_sum >>> 30;

  always_ff @(posedge clk) begin
    if (cmd.res) begin
      out_r <= sat16(gain_sh[23:0]);
    end
  end

  assign out_pink_sample = out_r;

endmodule

`default_nettype wire

// File: hdl/filtered_pink_noise_generator.sv
// Throughput is set by the walk over the octave rows (one row a cycle) and four
// passes through the one shared multiplier; a new sample is taken only from idle.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low) clears rows, sum, counter, filter state and
// loads the register defaults.
// ----------------------------------------------------------------------------
// filtered_pink_noise_generator: top level
// Voss-McCartney pink noise from a white sample stream, low-pass filtered
// and scaled by master and distance gains.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_pink_noise_generator import fpng_pkg::*; #(
  parameter int OCTAVES = OCTAVES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [GAIN_W-1:0]           cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [SAMPLE_W-1:0]  in_white_sample,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]       out_pink_sample
);

  localparam int IDXW = $clog2(OCTAVES);

  cmd_t            cmd;
  logic [IDXW-1:0] row_idx;

  // sequencer
  fpng_ctrl #(
    .OCTAVES (OCTAVES),
    .IDXW    (IDXW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .row_idx   (row_idx)
  );

  // arithmetic and state
  fpng_dp #(
    .OCTAVES (OCTAVES),
    .IDXW    (IDXW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_white_sample (in_white_sample),
    .cmd             (cmd),
    .row_idx         (row_idx),
    .out_pink_sample (out_pink_sample)
  );

endmodule

`default_nettype wire
